### design/dcwsg_pkg.sv
package dcwsg_pkg;

  localparam int IDX_W   = 10;
  localparam int RAW_W   = 14;
  localparam int AMP_W   = 17;
  localparam int DUTY_W  = 11;
  localparam int SHAPE_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam int TABLE_SAMPLES = 1024;
  localparam int ZERO_LEVEL    = 8192;
  localparam int TOP_RAW       = 16383;
  localparam int MID_SHIFT     = $clog2(ZERO_LEVEL);
  localparam int TRI_SHIFT     = 16 - MID_SHIFT;
  localparam int SIN_SHIFT     = 46 - MID_SHIFT;

  localparam logic [AMP_W-1:0] AMP_FULL = AMP_W'(65536);
  localparam logic [31:0]      PI_Q30   = 32'd3373259426;
  localparam logic [30:0]      Q30_ONE  = 31'h4000_0000;

  // long division: quotient bits, numerator and divisor widths
  localparam int Q_W   = 31;
  localparam int NUM_W = 42;
  localparam int DEN_W = 13;
  localparam int TERMS = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE     = 2'd2;

  localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 2'd2;

  typedef enum logic [1:0] {
    MODE_MID,
    MODE_SQUARE,
    MODE_TRI,
    MODE_SINE
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   idx;
    logic [AMP_W-1:0]   amp;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
  } fe_item_t;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [DUTY_W-1:0]  duty;
    logic [SHAPE_W-1:0] shape;
  } cfg_t;

endpackage

### design/dcwsg_if.sv
interface dcwsg_in_if;
  logic                        valid;
  logic                        ready;
  logic [dcwsg_pkg::IDX_W-1:0] sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface dcwsg_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcwsg_pkg::IDX_W-1:0] index_out;
  logic [dcwsg_pkg::RAW_W-1:0] raw_amplitude;
  modport source (output valid, output index_out, output raw_amplitude, input ready);
  modport sink   (input valid, input index_out, input raw_amplitude, output ready);
endinterface

### design/dcwsg_front.sv
module dcwsg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcwsg_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dcwsg_pkg::IDX_W-1:0]   in_idx,
  output logic                          fe_valid,
  input  logic                          fe_ready,
  output dcwsg_pkg::fe_item_t           fe_item
);

  logic                          f_vld_r, f_vld_nxt;
  dcwsg_pkg::fe_item_t           f_item_r, f_item_nxt;

  logic [dcwsg_pkg::AMP_W-1:0]   amp;
  logic [dcwsg_pkg::DUTY_W-1:0]  duty;
  logic [dcwsg_pkg::DUTY_W-1:0]  n;
  logic [dcwsg_pkg::DUTY_W-1:0]  fall_cnt;
  logic [dcwsg_pkg::DUTY_W-1:0]  fall_len;
  logic [dcwsg_pkg::IDX_W-1:0]   half;
  logic [dcwsg_pkg::IDX_W-1:0]   ip;
  logic                          active;
  logic                          long_enough;
  logic [31:0]                   mul_a;
  logic [dcwsg_pkg::DUTY_W-1:0]  mul_b;
  logic [42:0]                   prod;
  logic                          acc;

  assign acc      = in_valid && in_ready;
  assign in_ready = !f_vld_r || fe_ready;
  assign fe_valid = f_vld_r;
  assign fe_item  = f_item_r;

  always_comb begin
    amp  = (cfg.amp > dcwsg_pkg::AMP_FULL) ? dcwsg_pkg::AMP_FULL : cfg.amp;
    duty = (cfg.duty > dcwsg_pkg::DUTY_W'(dcwsg_pkg::TABLE_SAMPLES)) ?
           dcwsg_pkg::DUTY_W'(dcwsg_pkg::TABLE_SAMPLES) : cfg.duty;
    active      = {1'b0, in_idx} < duty;
    long_enough = duty >= dcwsg_pkg::DUTY_W'(2);
    n        = duty - dcwsg_pkg::DUTY_W'(1);
    half     = duty[dcwsg_pkg::DUTY_W-1:1];
    fall_cnt = duty - {1'b0, in_idx};
    fall_len = duty - {1'b0, half};
    // fold the half period about its centre
    ip = ({in_idx, 1'b0} > n) ? (n[dcwsg_pkg::IDX_W-1:0] - in_idx) : in_idx;

    f_item_nxt.idx = in_idx;
    f_item_nxt.amp = amp;
    f_item_nxt.den = dcwsg_pkg::DEN_W'(1);
    mul_a = 32'd0;
    mul_b = '0;
    f_item_nxt.mode = dcwsg_pkg::MODE_MID;

    case (cfg.shape)
      dcwsg_pkg::SHAPE_SQUARE: begin
        if (active) f_item_nxt.mode = dcwsg_pkg::MODE_SQUARE;
      end
      dcwsg_pkg::SHAPE_TRI: begin
        if (active && long_enough) begin
          f_item_nxt.mode = dcwsg_pkg::MODE_TRI;
          mul_a = 32'(amp);
          if (in_idx < half) begin
            mul_b = {1'b0, in_idx};
            f_item_nxt.den = dcwsg_pkg::DEN_W'(half) << dcwsg_pkg::TRI_SHIFT;
          end else begin
            mul_b = fall_cnt;
            f_item_nxt.den = dcwsg_pkg::DEN_W'(fall_len) << dcwsg_pkg::TRI_SHIFT;
          end
        end
      end
      default: begin
        if (active && long_enough) begin
          f_item_nxt.mode = dcwsg_pkg::MODE_SINE;
          mul_a = dcwsg_pkg::PI_Q30;
          mul_b = {1'b0, ip};
          f_item_nxt.den = dcwsg_pkg::DEN_W'(n);
        end
      end
    endcase

    prod = 43'(mul_a) * 43'(mul_b);
    f_item_nxt.num = prod[dcwsg_pkg::NUM_W-1:0];

    f_vld_nxt = acc ? 1'b1 : (fe_ready ? 1'b0 : f_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

### design/dcwsg_fifo.sv
module dcwsg_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### design/dcwsg_back.sv
module dcwsg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dcwsg_pkg::fe_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dcwsg_pkg::IDX_W-1:0]   out_idx,
  output logic [dcwsg_pkg::RAW_W-1:0]   out_raw
);

  localparam int QW  = dcwsg_pkg::Q_W;
  localparam int DW  = dcwsg_pkg::DEN_W;
  localparam int NS  = 2 * dcwsg_pkg::TERMS + 2;

  typedef struct packed {
    dcwsg_pkg::mode_t              mode;
    logic [dcwsg_pkg::IDX_W-1:0]   idx;
    logic [dcwsg_pkg::AMP_W-1:0]   amp;
    logic [DW-1:0]                 den;
    logic [DW-1:0]                 rem;
    logic [QW-1:0]                 lo;
    logic [QW-1:0]                 q;
  } div_st_t;

  typedef struct packed {
    dcwsg_pkg::mode_t              mode;
    logic [dcwsg_pkg::IDX_W-1:0]   idx;
    logic [dcwsg_pkg::AMP_W-1:0]   amp;
    logic [QW-1:0]                 q;
    logic [31:0]                   th2;
    logic [31:0]                   term;
    logic [31:0]                   sum;
  } sin_st_t;

  logic     adv;
  logic     dv_r [QW+1];
  div_st_t  div_r [QW+1];
  logic     sv_r [NS];
  sin_st_t  sin_r [NS];
  logic     mv_r;
  logic [dcwsg_pkg::IDX_W-1:0] m_idx_r;
  logic [dcwsg_pkg::RAW_W-1:0] m_mag_r;
  logic     out_vld_r;
  logic [dcwsg_pkg::IDX_W-1:0] out_idx_r;
  logic [dcwsg_pkg::RAW_W-1:0] out_raw_r;

  // whole pipe moves together; the output register frees as it is taken
  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_vld_r;
  assign out_idx   = out_idx_r;
  assign out_raw   = out_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0].mode <= in_item.mode;
      div_r[0].idx  <= in_item.idx;
      div_r[0].amp  <= in_item.amp;
      div_r[0].den  <= in_item.den;
      div_r[0].rem  <= DW'(in_item.num[dcwsg_pkg::NUM_W-1:QW]);
      div_r[0].lo   <= in_item.num[QW-1:0];
      div_r[0].q    <= '0;
    end
  end

  // restoring long division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW:0]   t;
    logic          ge;
    div_st_t       nx;
    always_comb begin
      t  = {div_r[j].rem, div_r[j].lo[QW-1]};
      ge = t >= {1'b0, div_r[j].den};
      nx = div_r[j];
      nx.rem = ge ? DW'(t - {1'b0, div_r[j].den}) : DW'(t);
      nx.lo  = {div_r[j].lo[QW-2:0], 1'b0};
      nx.q   = {div_r[j].q[QW-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= dv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) div_r[j+1] <= nx;
    end
  end

  // theta squared, rounded to Q30
  logic [62:0] sq;
  assign sq = 63'(div_r[QW].q) * 63'(div_r[QW].q) + 63'(1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_r[0].mode <= div_r[QW].mode;
      sin_r[0].idx  <= div_r[QW].idx;
      sin_r[0].amp  <= div_r[QW].amp;
      sin_r[0].q    <= div_r[QW].q;
      sin_r[0].th2  <= sq[61:30];
      sin_r[0].term <= 32'(div_r[QW].q);
      sin_r[0].sum  <= 32'(div_r[QW].q);
    end
  end

  // Taylor terms: stage 2m-1 multiplies by theta^2 and folds the previous
  // term into the sum; stage 2m divides by (2m)(2m+1) via exact reciprocal
  for (genvar m = 1; m <= dcwsg_pkg::TERMS; m++) begin : g_term
    localparam int K = (2 * m) * (2 * m + 1);
    localparam int S = 32 + $clog2(K);
    localparam logic [64:0] R = ((65'd1 << S) + 65'(K) - 65'd1) / 65'(K);

    logic [63:0] pa;
    logic [64:0] pb;
    sin_st_t     na, nb;

    always_comb begin
      pa = 64'(sin_r[2*m-2].term) * 64'(sin_r[2*m-2].th2);
      na = sin_r[2*m-2];
      na.term = pa[61:30];
      if (m > 1) begin
        if (((m - 1) % 2) == 1) begin
          na.sum = (sin_r[2*m-2].sum >= sin_r[2*m-2].term) ?
                   sin_r[2*m-2].sum - sin_r[2*m-2].term : 32'd0;
        end else begin
          na.sum = sin_r[2*m-2].sum + sin_r[2*m-2].term;
        end
      end
      pb = 65'(sin_r[2*m-1].term) * R;
      nb = sin_r[2*m-1];
      nb.term = 32'(pb >> S);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[2*m-1] <= 1'b0;
        sv_r[2*m]   <= 1'b0;
      end else if (adv) begin
        sv_r[2*m-1] <= sv_r[2*m-2];
        sv_r[2*m]   <= sv_r[2*m-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sin_r[2*m-1] <= na;
        sin_r[2*m]   <= nb;
      end
    end
  end

  // last term, bias and clamp to one
  localparam int LT = 2 * dcwsg_pkg::TERMS;
  logic [31:0] fsum;
  sin_st_t     nf;
  always_comb begin
    if ((dcwsg_pkg::TERMS % 2) == 1) begin
      fsum = (sin_r[LT].sum >= sin_r[LT].term) ? sin_r[LT].sum - sin_r[LT].term : 32'd0;
    end else begin
      fsum = sin_r[LT].sum + sin_r[LT].term;
    end
    fsum = fsum + 32'd8;
    nf = sin_r[LT];
    nf.sum = (fsum > 32'(dcwsg_pkg::Q30_ONE)) ? 32'(dcwsg_pkg::Q30_ONE) : fsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[NS-1] <= 1'b0;
    end else if (adv) begin
      sv_r[NS-1] <= sv_r[LT];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) sin_r[NS-1] <= nf;
  end

  // magnitude per mode
  logic [47:0]                 sp;
  logic [dcwsg_pkg::RAW_W-1:0] mag;
  always_comb begin
    sp = 48'(sin_r[NS-1].amp) * 48'(sin_r[NS-1].sum[30:0]);
    case (sin_r[NS-1].mode)
      dcwsg_pkg::MODE_SINE:   mag = dcwsg_pkg::RAW_W'(sp >> dcwsg_pkg::SIN_SHIFT);
      dcwsg_pkg::MODE_TRI:    mag = dcwsg_pkg::RAW_W'(sin_r[NS-1].q);
      dcwsg_pkg::MODE_SQUARE: mag = dcwsg_pkg::RAW_W'(sin_r[NS-1].amp >> dcwsg_pkg::TRI_SHIFT);
      default:                mag = '0;
    endcase
  end

  logic [dcwsg_pkg::RAW_W:0] lvl;
  assign lvl = (dcwsg_pkg::RAW_W+1)'(dcwsg_pkg::ZERO_LEVEL) + {1'b0, m_mag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      mv_r      <= sv_r[NS-1];
      out_vld_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_idx_r   <= sin_r[NS-1].idx;
      m_mag_r   <= mag;
      out_idx_r <= m_idx_r;
      out_raw_r <= (lvl > (dcwsg_pkg::RAW_W+1)'(dcwsg_pkg::TOP_RAW)) ?
                   dcwsg_pkg::RAW_W'(dcwsg_pkg::TOP_RAW) : lvl[dcwsg_pkg::RAW_W-1:0];
    end
  end

endmodule

### design/duty_cycled_waveform_sample_gen_top.sv
// channel   dir  handshake              payload
// in_ch     in   valid/ready            sample_index[9:0]
// out_ch    out  valid/ready            index_out[9:0], raw_amplitude[13:0]
// cfg_*     in   cfg_we, no back-press  cfg_index[1:0], cfg_wdata[16:0]
//
// One item per cycle sustained while out_ch takes its results; each taken item passes
// through the 31-stage pipelined long division followed by the 22-stage
// sine series pipe.
// Front stage and back pipe are split by a two-entry queue; the back pipe
// halts as a whole while its output register holds an untaken result.
// Synchronous active-low reset clears valid flags and config (all zero).
module duty_cycled_waveform_sample_gen_top (
  input  logic                              clk,
  input  logic                              rst_n,
  dcwsg_in_if.sink                          in_ch,
  dcwsg_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [dcwsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcwsg_pkg::AMP_W-1:0]       cfg_wdata
);

  dcwsg_pkg::cfg_t     cfg_r;
  logic                fe_valid, fe_ready;
  dcwsg_pkg::fe_item_t fe_item;
  logic                q_valid, q_ready;
  logic [$bits(dcwsg_pkg::fe_item_t)-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dcwsg_pkg::CFG_AMPLITUDE: cfg_r.amp   <= cfg_wdata;
        dcwsg_pkg::CFG_ACTIVE:    cfg_r.duty  <= cfg_wdata[dcwsg_pkg::DUTY_W-1:0];
        dcwsg_pkg::CFG_SHAPE:     cfg_r.shape <= cfg_wdata[dcwsg_pkg::SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  dcwsg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_idx   (in_ch.sample_index),
    .fe_valid (fe_valid),
    .fe_ready (fe_ready),
    .fe_item  (fe_item)
  );

  dcwsg_fifo #(
    .W     ($bits(dcwsg_pkg::fe_item_t)),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  dcwsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (dcwsg_pkg::fe_item_t'(q_data)),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_idx   (out_ch.index_out),
    .out_raw   (out_ch.raw_amplitude)
  );

endmodule

### tb/duty_cycled_waveform_sample_gen_top_test.sv
module duty_cycled_waveform_sample_gen_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dcwsg_pkg::SHAPE_W-1:0] SHAPE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 80;

  class burst_sample_board;
    typedef struct {
      logic [dcwsg_pkg::IDX_W-1:0] idx;
      logic [dcwsg_pkg::RAW_W-1:0] raw;
      bit                          sine;
    } sample_t;

    sample_t          pending[$];
    logic [dcwsg_pkg::AMP_W-1:0]   amp_reg;
    logic [dcwsg_pkg::DUTY_W-1:0]  duty_reg;
    logic [dcwsg_pkg::SHAPE_W-1:0] shape_reg;
    int errors;
    int checked;

    function new();
      amp_reg = '0;
      duty_reg = '0;
      shape_reg = '0;
      errors = 0;
      checked = 0;
    endfunction

    function longint unsigned sine_q30(longint unsigned theta);
      longint unsigned th2, term, sum;
      th2 = (theta * theta + (64'd1 << 29)) >> 30;
      term = theta;
      sum = theta;
      for (int m = 1; m <= 10; m++) begin
        term = ((term * th2) >> 30) / ((2 * m) * (2 * m + 1));
        if (m % 2 == 1) sum = (sum >= term) ? sum - term : 0;
        else sum += term;
      end
      sum += 8;
      if (sum > 64'd1073741824) sum = 64'd1073741824;
      return sum;
    endfunction

    function void note(logic [dcwsg_pkg::IDX_W-1:0] idx);
      sample_t s;
      longint unsigned i, amp, duty, mag, half, n, ip, level;
      i = idx;
      amp = (amp_reg > dcwsg_pkg::AMP_FULL) ? 65536 : amp_reg;
      duty = (duty_reg > dcwsg_pkg::TABLE_SAMPLES) ? dcwsg_pkg::TABLE_SAMPLES : duty_reg;
      mag = 0;
      s.sine = 0;
      if (i < duty) begin
        if (shape_reg == dcwsg_pkg::SHAPE_SQUARE) begin
          mag = (amp * dcwsg_pkg::ZERO_LEVEL) >> 16;
        end else if (shape_reg == dcwsg_pkg::SHAPE_TRI) begin
          if (duty >= 2) begin
            half = duty / 2;
            if (i < half) mag = (amp * i * dcwsg_pkg::ZERO_LEVEL) / (65536 * half);
            else mag = (amp * (duty - i) * dcwsg_pkg::ZERO_LEVEL) / (65536 * (duty - half));
          end
        end else if (duty >= 2) begin
          n = duty - 1;
          ip = (2 * i > n) ? n - i : i;
          mag = (amp * dcwsg_pkg::ZERO_LEVEL * sine_q30((64'd3373259426 * ip) / n)) >> 46;
          s.sine = 1;
        end
      end
      level = dcwsg_pkg::ZERO_LEVEL + mag;
      if (level > dcwsg_pkg::TOP_RAW) level = dcwsg_pkg::TOP_RAW;
      s.idx = idx;
      s.raw = level[dcwsg_pkg::RAW_W-1:0];
      pending.insert(pending.size(), s);
    endfunction

    function void check(logic [dcwsg_pkg::IDX_W-1:0] idx, logic [dcwsg_pkg::RAW_W-1:0] raw);
      sample_t s;
      int diff;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: idx %0d raw %0d", idx, raw);
        return;
      end
      s = pending.pop_front();
      diff = int'(raw) - int'(s.raw);
      // sine tolerates one LSB either way
      if (idx !== s.idx || (s.sine ? (diff > 1 || diff < -1) : raw !== s.raw)) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected idx %0d raw %0d, got idx %0d raw %0d",
                   s.idx, s.raw, idx, raw);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [dcwsg_pkg::CFG_IDX_W-1:0] cfg_index = dcwsg_pkg::CFG_AMPLITUDE;
  logic [dcwsg_pkg::AMP_W-1:0] cfg_wdata = '0;
  dcwsg_in_if  in_ch();
  dcwsg_out_if out_ch();
  burst_sample_board board = new();
  int phases = 0;

  always #5 clk = ~clk;

  duty_cycled_waveform_sample_gen_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task write_reg(logic [dcwsg_pkg::CFG_IDX_W-1:0] idx, logic [dcwsg_pkg::AMP_W-1:0] value);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      dcwsg_pkg::CFG_AMPLITUDE: board.amp_reg = value;
      dcwsg_pkg::CFG_ACTIVE:    board.duty_reg = value[dcwsg_pkg::DUTY_W-1:0];
      default:                  board.shape_reg = value[dcwsg_pkg::SHAPE_W-1:0];
    endcase
  endtask

  task end_items();
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task set_burst(logic [dcwsg_pkg::AMP_W-1:0] amp, logic [dcwsg_pkg::DUTY_W-1:0] duty,
                 logic [dcwsg_pkg::SHAPE_W-1:0] shape);
    // valid may still be up after a back-to-back item
    end_items();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(dcwsg_pkg::CFG_AMPLITUDE, amp);
    write_reg(dcwsg_pkg::CFG_ACTIVE, dcwsg_pkg::AMP_W'(duty));
    write_reg(dcwsg_pkg::CFG_SHAPE, dcwsg_pkg::AMP_W'(shape));
    phases++;
  endtask

  task send_sample(logic [dcwsg_pkg::IDX_W-1:0] idx, bit burst);
    int g;
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.sample_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    board.note(idx);
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid = 0;
      in_ch.sample_index = dcwsg_pkg::IDX_W'($urandom);
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // output side: random stalls, with quiet stretches
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check(out_ch.index_out, out_ch.raw_amplitude);
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready = 0;
      end else begin
        out_ch.ready = 1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  initial begin
    #5ms;
    $display("[duty_cycled_waveform_sample_gen_top] ERROR");
    $finish;
  end

  initial begin
    int duty_sat;
    bit burst;
    logic [dcwsg_pkg::AMP_W-1:0] amp;
    logic [dcwsg_pkg::DUTY_W-1:0] duty;
    in_ch.valid = 0;
    in_ch.sample_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, every shape, short bursts, oversize registers
    set_burst(dcwsg_pkg::AMP_W'(65536), 11'd1024, dcwsg_pkg::SHAPE_SINE);
    send_sample(10'd0, 0); send_sample(10'd1, 0);
    send_sample(10'd511, 0); send_sample(10'd1023, 0);
    set_burst(17'h1FFFF, 11'h7FF, SHAPE_SPARE);
    send_sample(10'd0, 1); send_sample(10'd512, 1); send_sample(10'd1023, 1);
    set_burst(dcwsg_pkg::AMP_W'(65536), 11'd1, dcwsg_pkg::SHAPE_SINE);
    send_sample(10'd0, 0); send_sample(10'd1, 0);
    set_burst(dcwsg_pkg::AMP_W'(65536), 11'd1, dcwsg_pkg::SHAPE_TRI);
    send_sample(10'd0, 0);
    set_burst(dcwsg_pkg::AMP_W'(65536), 11'd1, dcwsg_pkg::SHAPE_SQUARE);
    send_sample(10'd0, 0); send_sample(10'd1, 0);
    set_burst(17'h1FFFF, 11'd2, dcwsg_pkg::SHAPE_TRI);
    send_sample(10'd0, 0); send_sample(10'd1, 0); send_sample(10'd2, 0);
    set_burst(dcwsg_pkg::AMP_W'(40000), 11'd2, dcwsg_pkg::SHAPE_SINE);
    send_sample(10'd0, 0); send_sample(10'd1, 0);
    set_burst('0, 11'd0, dcwsg_pkg::SHAPE_SQUARE);
    send_sample(10'd0, 0); send_sample(10'd1023, 0);
    set_burst(dcwsg_pkg::AMP_W'(65535), 11'd1024, dcwsg_pkg::SHAPE_TRI);
    send_sample(10'd511, 0); send_sample(10'd512, 0); send_sample(10'd1023, 0);
    end_items();

    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 3))
        0: amp = dcwsg_pkg::AMP_W'(65536);
        1: amp = dcwsg_pkg::AMP_W'($urandom);
        default: amp = dcwsg_pkg::AMP_W'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 4))
        0: duty = dcwsg_pkg::DUTY_W'($urandom);
        1: duty = dcwsg_pkg::DUTY_W'($urandom_range(0, 4));
        default: duty = dcwsg_pkg::DUTY_W'($urandom_range(2, 1024));
      endcase
      set_burst(amp, duty, dcwsg_pkg::SHAPE_W'($urandom));
      duty_sat = (duty > dcwsg_pkg::TABLE_SAMPLES) ? dcwsg_pkg::TABLE_SAMPLES : duty;
      burst = $urandom_range(0, 2) == 0;
      for (int k = 0; k < 50; k++) begin
        if (duty_sat > 0 && $urandom_range(0, 9) < 7)
          send_sample(dcwsg_pkg::IDX_W'($urandom_range(0, duty_sat - 1)), burst);
        else
          send_sample(dcwsg_pkg::IDX_W'($urandom), burst);
      end
      end_items();
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending.size() != 0) board.errors += board.pending.size();
    $display("covered %0d burst settings, %0d samples checked, %0d errors",
             phases, board.checked, board.errors);
    if (board.errors == 0)
      $display("[duty_cycled_waveform_sample_gen_top] OK");
    else
      $display("[duty_cycled_waveform_sample_gen_top] ERROR");
    $finish;
  end
endmodule
